// ----- sv/scle_pkg.sv -----
`default_nettype none
package scle_pkg;

	localparam int LINE_CAPACITY_DEF = 32;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	typedef enum logic [1:0] {
		CLS_LF,
		CLS_CR,
		CLS_ERASE,
		CLS_OTHER
	} byte_cls_t;

	typedef enum logic [2:0] {
		SEL_CR,
		SEL_LF,
		SEL_SP,
		SEL_CHAR,
		SEL_MEM
	} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_NL_CR,
		S_NL_LF,
		S_ER_C1,
		S_ER_SP,
		S_ER_C2,
		S_ST,
		S_EN_CR1,
		S_EN_CR2,
		S_EN_LF,
		S_RD,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic     cap;
		logic     load;
		out_sel_t sel;
		logic     to_line;
		logic     last;
		logic     wr_store;
		logic     dec_fill;
		logic     rd_issue;
		logic     dump_done;
	} dp_cmd_t;

	typedef struct packed {
		byte_cls_t cls;
		logic      fill_zero;
		logic      fill_full;
		logic      out_free;
		logic      dump_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/scle_datapath.sv -----
`default_nettype none
module scle_datapath #(
	parameter int LINE_CAPACITY = scle_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        in_byte,
	input  wire scle_pkg::dp_cmd_t cmd,
	output scle_pkg::dp_stat_t     stat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_to_line,
	output logic                   out_last
);
	import scle_pkg::*;

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int CNT_W = $clog2(LINE_CAPACITY);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       char_q;
	logic [7:0]       rdata_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             to_line_q;
	logic             last_q;
	logic [7:0]       sel_byte;

	// line store
	always_ff @(posedge clk) begin
		if (cmd.wr_store) begin
			mem[fill_q[IDX_W-1:0]] <= char_q;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			char_q <= in_byte;
		end
		if (cmd.load) begin
			byte_q    <= sel_byte;
			to_line_q <= cmd.to_line;
			last_q    <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_cnt_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.dump_done) begin
				fill_q   <= '0;
				rd_cnt_q <= '0;
			end else begin
				if (cmd.wr_store) begin
					fill_q <= fill_q + ONE_C;
				end else if (cmd.dec_fill && fill_q != '0) begin
					fill_q <= fill_q - ONE_C;
				end
				if (cmd.rd_issue) begin
					rd_cnt_q <= rd_cnt_q + ONE_C;
				end
			end
			if (cmd.load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_CR:   sel_byte = CH_CR;
			SEL_LF:   sel_byte = CH_LF;
			SEL_SP:   sel_byte = CH_SP;
			SEL_CHAR: sel_byte = char_q;
			SEL_MEM:  sel_byte = rdata_q;
			default:  sel_byte = char_q;
		endcase
	end

	always_comb begin
		priority if (char_q == CH_LF) begin
			stat.cls = CLS_LF;
		end else if (char_q == CH_CR) begin
			stat.cls = CLS_CR;
		end else if (char_q == CH_BS || char_q == CH_DEL) begin
			stat.cls = CLS_ERASE;
		end else begin
			stat.cls = CLS_OTHER;
		end
		stat.fill_zero = (fill_q == '0);
		stat.fill_full = (fill_q >= DEPTH_C);
		stat.out_free  = !valid_q || out_ready;
		stat.dump_last = (rd_cnt_q == fill_q);
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign out_to_line = to_line_q;
	assign out_last    = last_q;

endmodule
`default_nettype wire

// ----- sv/scle_ctrl.sv -----
`default_nettype none
module scle_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire scle_pkg::dp_stat_t stat,
	output scle_pkg::dp_cmd_t       cmd
);
	import scle_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				priority if (stat.cls == CLS_LF || (stat.cls == CLS_CR && stat.fill_zero)) begin
					state_d = S_NL_CR;
				end else if (stat.cls == CLS_ERASE) begin
					state_d = S_ER_C1;
				end else if (stat.cls == CLS_CR) begin
					state_d = S_EN_CR1;
				end else if (stat.fill_full) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_ST;
				end
			end
			S_NL_CR:  if (stat.out_free) state_d = S_NL_LF;
			S_NL_LF:  if (stat.out_free) state_d = S_IDLE;
			S_ER_C1:  if (stat.out_free) state_d = S_ER_SP;
			S_ER_SP:  if (stat.out_free) state_d = S_ER_C2;
			S_ER_C2:  if (stat.out_free) state_d = S_IDLE;
			S_ST:     if (stat.out_free) state_d = S_IDLE;
			S_EN_CR1: if (stat.out_free) state_d = S_EN_CR2;
			S_EN_CR2: if (stat.out_free) state_d = S_EN_LF;
			S_EN_LF:  if (stat.out_free) state_d = S_RD;
			S_RD:     state_d = S_DUMP;
			S_DUMP: begin
				if (stat.out_free && stat.dump_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_CHAR;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			S_DECODE: ;
			S_NL_CR: begin
				cmd.load = stat.out_free;
				cmd.sel  = SEL_CR;
			end
			S_NL_LF: begin
				cmd.load = stat.out_free;
				cmd.sel  = SEL_LF;
				cmd.last = 1'b1;
			end
			S_ER_C1: begin
				cmd.load = stat.out_free;
			end
			S_ER_SP: begin
				cmd.load = stat.out_free;
				cmd.sel  = SEL_SP;
			end
			S_ER_C2: begin
				cmd.load     = stat.out_free;
				cmd.last     = 1'b1;
				cmd.dec_fill = stat.out_free;
			end
			S_ST: begin
				cmd.load     = stat.out_free;
				cmd.last     = 1'b1;
				cmd.wr_store = stat.out_free;
			end
			S_EN_CR1, S_EN_CR2: begin
				cmd.load = stat.out_free;
				cmd.sel  = SEL_CR;
			end
			S_EN_LF: begin
				cmd.load = stat.out_free;
				cmd.sel  = SEL_LF;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
			end
			S_DUMP: begin
				cmd.load      = stat.out_free;
				cmd.sel       = SEL_MEM;
				cmd.to_line   = 1'b1;
				cmd.last      = stat.dump_last;
				cmd.rd_issue  = stat.out_free && !stat.dump_last;
				cmd.dump_done = stat.out_free && stat.dump_last;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/serial_console_line_editor_unit.sv -----
// channel   dir  tdata          tuser      tlast
// s_axis    in   rx_byte[7:0]   -          -
// m_axis    out  out_byte[7:0]  to_line    last
//
// a received byte is captured while idle, decoded, then echoed one transfer
// at a time; a line dump first issues a store read, then sends the line bytes
// from the store, issuing the next read as each byte is loaded for output
// reset clears the state machine, fill count and output valid; the line
// store itself is not cleared
// a stalled m_axis holds the sequencer in place; s_axis is ready only when idle
`default_nettype none
module serial_console_line_editor_unit #(
	parameter int LINE_CAPACITY = scle_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // rx_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // out_byte
	output logic            m_axis_tuser,   // to_line
	output logic            m_axis_tlast
);
	import scle_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	scle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scle_datapath #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_axis_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_to_line (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ----- test/line_echo_checker.sv -----
`default_nettype none
module line_echo_checker #(
	parameter int LINE_CAPACITY = scle_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	input  wire logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,
	input  wire logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	input  wire logic [7:0] m_axis_tdata,
	input  wire logic       m_axis_tuser,
	input  wire logic       m_axis_tlast,
	output int              mismatches,
	output int              pending
);
	import scle_pkg::*;

	localparam int LINE_MAX = LINE_CAPACITY - 1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_line;
		logic       last;
	} echo_beat_t;

	echo_beat_t  echo_q[$];
	logic [7:0]  line_buf [LINE_MAX];
	int          line_fill;

	function automatic void queue_beat(input logic [7:0] b, input logic to_line);
		echo_beat_t beat;
		beat.out_byte = b;
		beat.to_line  = to_line;
		beat.last     = 1'b0;
		echo_q.push_back(beat);
	endfunction

	// expected echo and command bytes for one received key
	function automatic void edit_line(input logic [7:0] c);
		int start;
		start = echo_q.size();
		if (c == CH_LF || (c == CH_CR && line_fill == 0)) begin
			queue_beat(CH_CR, 1'b0);
			queue_beat(CH_LF, 1'b0);
		end else if (c == CH_BS || c == CH_DEL) begin
			queue_beat(c, 1'b0);
			queue_beat(CH_SP, 1'b0);
			queue_beat(c, 1'b0);
			if (line_fill > 0)
				line_fill--;
		end else if (c == CH_CR) begin
			queue_beat(CH_CR, 1'b0);
			queue_beat(CH_CR, 1'b0);
			queue_beat(CH_LF, 1'b0);
			for (int i = 0; i < line_fill; i++)
				queue_beat(line_buf[i], 1'b1);
			line_fill = 0;
		end else if (line_fill < LINE_MAX) begin
			queue_beat(c, 1'b0);
			line_buf[line_fill] = c;
			line_fill++;
		end
		if (echo_q.size() > start)
			echo_q[echo_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_fill = 0;
			echo_q.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (echo_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transfer out_byte %02h to_line %0b last %0b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					echo_beat_t want;
					want = echo_q.pop_front();
					if (want.out_byte !== m_axis_tdata)
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.out_byte, m_axis_tdata);
					if (want.to_line !== m_axis_tuser)
						$display("%0t: to_line expected %0b actual %0b",
							$time, want.to_line, m_axis_tuser);
					if (want.last !== m_axis_tlast)
						$display("%0t: last expected %0b actual %0b",
							$time, want.last, m_axis_tlast);
					if (want !== {m_axis_tdata, m_axis_tuser, m_axis_tlast})
						mismatches++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				edit_line(s_axis_tdata);
			pending = echo_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- test/serial_console_line_editor_unit_test.sv -----
`default_nettype none
module serial_console_line_editor_unit_test;
	import scle_pkg::*;

	localparam int LINE_CAPACITY = LINE_CAPACITY_DEF;
	localparam int LINE_MAX      = LINE_CAPACITY - 1;
	localparam int KEY_TOTAL     = 470;
	localparam int CYCLE_LIMIT   = 500000;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	int mismatches;
	int pending;
	int send_idle = 21;
	int recv_idle = 72;
	int keys_sent = 0;

	serial_console_line_editor_unit #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	line_echo_checker #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_key(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		keys_sent++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] plain_key();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
		return b;
	endfunction

	// random content, with erases mixed in when erase_pct is nonzero, closed by cr
	task automatic type_line(input int len, input int erase_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < erase_pct)
				send_key($urandom_range(0, 1) ? CH_DEL : CH_BS);
			else
				send_key(plain_key());
		end
		send_key(CH_CR);
	endtask

	initial begin
		logic [7:0] directed [$];
		int pick;
		directed = '{8'h00, 8'hff, CH_BS, CH_DEL, CH_CR, CH_LF, 8'h41, 8'h80, 8'h01,
			CH_BS, 8'h7e, CH_DEL, 8'h55, 8'haa, CH_LF, CH_CR, CH_CR, 8'h0c};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_key(directed[i]);
		send_key(CH_CR);
		drain;

		while (keys_sent < KEY_TOTAL) begin
			if (keys_sent >= 2 * KEY_TOTAL / 3 && send_idle != 0) begin
				drain;
				send_idle = 0;
				recv_idle = 0;
			end else if (keys_sent >= KEY_TOTAL / 3 && send_idle == 21) begin
				drain;
				send_idle = 72;
				recv_idle = 21;
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				send_key(8'($urandom_range(0, 255)));
			else if (pick < 22)
				type_line(LINE_MAX + $urandom_range(0, 5), 0);
			else if (pick < 28)
				send_key($urandom_range(0, 1) ? CH_LF : CH_CR);
			else if (pick < 32)
				drain;
			else
				type_line($urandom_range(0, 12), 15);
		end

		drain;
		repeat (LINE_CAPACITY + 10) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
